// ----- rtl/mrac_tlc_pkg.sv -----
// Shared types, constants and the step program for the tank level controller.
// No dependencies; used by every rtl file of the block.
`default_nettype none
package mrac_tlc_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int OP_HEIGHT_DEF  = 6554;
	localparam int BASE_DRIVE_DEF = 0;

	// round(2^32 / (100 * pi * 3.75^2)): grams to meters of height
	localparam logic signed [31:0] HEIGHT_K  = 32'sd972182;
	localparam logic signed [31:0] TICK_RATE = 32'sd1000;
	localparam logic signed [31:0] DUTY_FULL = 32'sd255;
	localparam int DEAD_BAND_UNITS = 5;

	// floor(n / 1000) = (n * RECIP_TICK) >> RECIP_SHIFT for any n below 2^32
	localparam logic [31:0] RECIP_TICK = 32'd274877907;
	localparam int RECIP_SHIFT = 38;
	localparam int TQ_W = 26;

	localparam logic signed [31:0] RST_ONE = 32'sd65536;
	localparam logic signed [31:0] RST_TWO = 32'sd131072;
	localparam logic [23:0] RST_DRIVE_MAX  = 24'd786432;

	localparam int DVD_W = 33;
	localparam int DVS_W = 24;
	localparam int CFG_IDX_W = 4;

	localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REF       = 4'd0,
		REG_A0        = 4'd1,
		REG_A1        = 4'd2,
		REG_P1        = 4'd3,
		REG_P2        = 4'd4,
		REG_GAIN_ST   = 4'd5,
		REG_GAIN_REF  = 4'd6,
		REG_DRIVE_MAX = 4'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLAMP_NONE = 2'd0,
		CLAMP_LOW  = 2'd1,
		CLAMP_HIGH = 2'd2
	} clamp_t;

	typedef enum logic [5:0] {
		OP_MUL_H, OP_H, OP_X1, OP_MUL_DIF, OP_X2,
		OP_MUL_A1V, OP_MUL_A0P, OP_MUL_A0R,
		OP_ACC_NEG, OP_ACC_SUB, OP_ACC_ADD, OP_ACC_LD,
		OP_DIV_ACC, OP_EUL_MV, OP_DIV_MV, OP_EUL_MP, OP_ERR,
		OP_MUL_E1, OP_MUL_E2, OP_EP,
		OP_MUL_SX1, OP_MUL_SX2, OP_MUL_RR, OP_T, OP_MUL_TEP, OP_DQ, OP_DIV_T,
		OP_EUL_GP, OP_EUL_GR, OP_EUL_GF,
		OP_MUL_UP, OP_MUL_UR, OP_MUL_UF, OP_CLAMP,
		OP_MUL_DUTY, OP_DIV_DUTY, OP_EMIT
	} op_t;

	localparam int PC_W = 6;

	typedef struct packed {
		logic load;
		logic exec;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_stat_t;

	function automatic op_t prog_op(input logic [PC_W-1:0] pc);
		op_t o;
		unique case (pc)
			6'd0:  o = OP_MUL_H;
			6'd1:  o = OP_H;
			6'd2:  o = OP_X1;
			6'd3:  o = OP_MUL_DIF;
			6'd4:  o = OP_X2;
			6'd5:  o = OP_MUL_A1V;
			6'd6:  o = OP_ACC_NEG;
			6'd7:  o = OP_MUL_A0P;
			6'd8:  o = OP_ACC_SUB;
			6'd9:  o = OP_MUL_A0R;
			6'd10: o = OP_ACC_ADD;
			6'd11: o = OP_DIV_ACC;
			6'd12: o = OP_EUL_MV;
			6'd13: o = OP_DIV_MV;
			6'd14: o = OP_EUL_MP;
			6'd15: o = OP_ERR;
			6'd16: o = OP_MUL_E1;
			6'd17: o = OP_ACC_LD;
			6'd18: o = OP_MUL_E2;
			6'd19: o = OP_ACC_ADD;
			6'd20: o = OP_EP;
			6'd21: o = OP_MUL_SX1;
			6'd22: o = OP_T;
			6'd23: o = OP_MUL_TEP;
			6'd24: o = OP_DQ;
			6'd25: o = OP_DIV_T;
			6'd26: o = OP_EUL_GP;
			6'd27: o = OP_MUL_SX2;
			6'd28: o = OP_T;
			6'd29: o = OP_MUL_TEP;
			6'd30: o = OP_DQ;
			6'd31: o = OP_DIV_T;
			6'd32: o = OP_EUL_GR;
			6'd33: o = OP_MUL_RR;
			6'd34: o = OP_T;
			6'd35: o = OP_MUL_TEP;
			6'd36: o = OP_DQ;
			6'd37: o = OP_DIV_T;
			6'd38: o = OP_EUL_GF;
			6'd39: o = OP_MUL_UP;
			6'd40: o = OP_ACC_LD;
			6'd41: o = OP_MUL_UR;
			6'd42: o = OP_ACC_ADD;
			6'd43: o = OP_MUL_UF;
			6'd44: o = OP_ACC_ADD;
			6'd45: o = OP_CLAMP;
			6'd46: o = OP_MUL_DUTY;
			6'd47: o = OP_DIV_DUTY;
			default: o = OP_EMIT;
		endcase
		return o;
	endfunction

	// only the duty ratio waits on the serial divider; tick steps use a reciprocal
	function automatic logic is_div(input op_t o);
		return (o == OP_DIV_DUTY);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX)
			r = 32'sh7FFFFFFF;
		else if (v < S32_MIN)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/mrac_tank_level_controller_unit.sv -----
// Top level of the adaptive tank level controller: sequencer plus datapath.
// Depends on mrac_tlc_pkg, mrac_tlc_ctrl, mrac_tlc_dp, mrac_tlc_div.
//
//  channel | signals                                  | accepted when
//  input   | in_valid, in_stall, load_weight          | in_valid && !in_stall
//  output  | out_valid, out_stall, pump_duty,         | out_valid && !out_stall
//          | control_effort, effort_clamped           |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid && cfg_ready
//
// Each item runs from its accept through 49 program steps and one wait on the
// bit-serial divider for the duty ratio; a new item is taken only once the last is emitted.
// The multiplier is shared and registered, at most one product per step; the 1 ms tick
// divisions use a reciprocal multiply within their step.
// Reset restores register defaults and clears the controller state at once.
// A held output stalls the final step, and the input stays stalled until it runs.
`default_nettype none
module mrac_tank_level_controller_unit #(
	parameter int FRAC_BITS        = mrac_tlc_pkg::FRAC_BITS_DEF,
	parameter int OPERATING_HEIGHT = mrac_tlc_pkg::OP_HEIGHT_DEF,
	parameter int BASE_DRIVE       = mrac_tlc_pkg::BASE_DRIVE_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [23:0]                 load_weight,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [7:0]                              pump_duty,
	output logic [23:0]                             control_effort,
	output logic [1:0]                              effort_clamped,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [mrac_tlc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                        cfg_data
);
	mrac_tlc_pkg::dp_cmd_t  cmd;
	mrac_tlc_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	mrac_tlc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	mrac_tlc_dp #(
		.FRAC_BITS        (FRAC_BITS),
		.OPERATING_HEIGHT (OPERATING_HEIGHT),
		.BASE_DRIVE       (BASE_DRIVE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.load_weight    (load_weight),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pump_duty      (pump_duty),
		.control_effort (control_effort),
		.effort_clamped (effort_clamped)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken but sequencer not busy");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(control_effort)))
		else $error("held result changed");

	a_flag_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (effort_clamped != 2'd3))
		else $error("bad clamp code");

	a_zero_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && effort_clamped == mrac_tlc_pkg::CLAMP_LOW) |->
		(control_effort == '0 && pump_duty == '0))
		else $error("low clamp with nonzero drive");
endmodule
`default_nettype wire

// ----- rtl/mrac_tlc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mrac_tlc_pkg for operand widths.
`default_nettype none
module mrac_tlc_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [mrac_tlc_pkg::DVD_W-1:0]   dividend,
	input  wire logic [mrac_tlc_pkg::DVS_W-1:0]   divisor,
	output logic                                  done,
	output logic [mrac_tlc_pkg::DVD_W-1:0]        quotient
);
	localparam int DW = mrac_tlc_pkg::DVD_W;
	localparam int SW = mrac_tlc_pkg::DVS_W;
	localparam int CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    rem_q, dvs_q;
	logic [DW-1:0]    dq_q;
	logic [SW:0]      sh, trial;
	logic             fits;

	assign sh    = {rem_q, dq_q[DW-1]};
	assign fits  = sh >= {1'b0, dvs_q};
	assign trial = sh - {1'b0, dvs_q};
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial[SW-1:0] : sh[SW-1:0];
			dq_q  <= {dq_q[DW-2:0], fits};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/mrac_tlc_dp.sv -----
// Datapath: config registers, controller state, shared multiplier and divider.
// Depends on mrac_tlc_pkg and mrac_tlc_div; driven by mrac_tlc_ctrl commands.
`default_nettype none
module mrac_tlc_dp #(
	parameter int FRAC_BITS        = mrac_tlc_pkg::FRAC_BITS_DEF,
	parameter int OPERATING_HEIGHT = mrac_tlc_pkg::OP_HEIGHT_DEF,
	parameter int BASE_DRIVE       = mrac_tlc_pkg::BASE_DRIVE_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire mrac_tlc_pkg::dp_cmd_t                cmd,
	output mrac_tlc_pkg::dp_stat_t                    stat,
	input  wire logic signed [23:0]                   load_weight,
	input  wire logic                                 cfg_we,
	input  wire logic [mrac_tlc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                          cfg_data,
	output logic [7:0]                                pump_duty,
	output logic [23:0]                               control_effort,
	output logic [1:0]                                effort_clamped
);
	localparam logic signed [33:0] BAND = 34'(mrac_tlc_pkg::DEAD_BAND_UNITS) <<< FRAC_BITS;
	localparam int DW = mrac_tlc_pkg::DVD_W;
	localparam int SW = mrac_tlc_pkg::DVS_W;
	localparam int TQ_W = mrac_tlc_pkg::TQ_W;

	logic signed [31:0] ref_q, a0_q, a1_q, p1_q, p2_q, gs_q, gr_cfg_q;
	logic [23:0]        dmax_q;
	logic signed [31:0] prev_q, mp_q, mv_q, gp_q, grt_q, gf_q;
	logic signed [23:0] w_q;
	logic signed [31:0] h_q, x1_q, x2_q, e1_q, e2_q, ep_q, t_q;
	logic signed [34:0] acc_q;
	logic signed [63:0] p_q;
	logic [23:0]        u_q;
	logic [1:0]         flag_q;
	logic               band_ok_q, div_neg_q;
	logic [TQ_W-1:0]    tq_q;

	logic signed [31:0] ma, mb, qm, hs, dif, dsrc;
	logic signed [32:0] dsrc33;
	logic signed [33:0] qs;
	logic [31:0]        mag;
	logic [63:0]        recip_p;
	logic [TQ_W-1:0]    tq;
	logic [DW-1:0]      dvd, quo;
	logic [SW-1:0]      dvs;
	logic               dneg, div_start, do_mul;
	logic signed [35:0] s_drive;
	logic [23:0]        u_new;
	logic [1:0]         f_new;

	assign qm  = mrac_tlc_pkg::sat32(66'(p_q >>> FRAC_BITS));
	assign hs  = mrac_tlc_pkg::sat32(66'(p_q >>> (40 - FRAC_BITS)));
	assign dif = mrac_tlc_pkg::sat32(66'(x1_q) - 66'(prev_q));
	assign qs  = div_neg_q ? -34'($signed({1'b0, tq_q})) : 34'($signed({1'b0, tq_q}));

	// operand select for the shared multiplier
	always_comb begin
		do_mul = 1'b1;
		ma = '0;
		mb = '0;
		case (cmd.op)
			mrac_tlc_pkg::OP_MUL_H:    begin ma = 32'(w_q); mb = mrac_tlc_pkg::HEIGHT_K; end
			mrac_tlc_pkg::OP_MUL_DIF:  begin ma = dif; mb = mrac_tlc_pkg::TICK_RATE; end
			mrac_tlc_pkg::OP_MUL_A1V:  begin ma = a1_q; mb = mv_q; end
			mrac_tlc_pkg::OP_MUL_A0P:  begin ma = a0_q; mb = mp_q; end
			mrac_tlc_pkg::OP_MUL_A0R:  begin ma = a0_q; mb = ref_q; end
			mrac_tlc_pkg::OP_MUL_E1:   begin ma = e1_q; mb = p1_q; end
			mrac_tlc_pkg::OP_MUL_E2:   begin ma = e2_q; mb = p2_q; end
			mrac_tlc_pkg::OP_MUL_SX1:  begin ma = gs_q; mb = x1_q; end
			mrac_tlc_pkg::OP_MUL_SX2:  begin ma = gs_q; mb = x2_q; end
			mrac_tlc_pkg::OP_MUL_RR:   begin ma = gr_cfg_q; mb = ref_q; end
			mrac_tlc_pkg::OP_MUL_TEP:  begin ma = t_q; mb = ep_q; end
			mrac_tlc_pkg::OP_MUL_UP:   begin ma = gp_q; mb = x1_q; end
			mrac_tlc_pkg::OP_MUL_UR:   begin ma = grt_q; mb = x2_q; end
			mrac_tlc_pkg::OP_MUL_UF:   begin ma = gf_q; mb = ref_q; end
			mrac_tlc_pkg::OP_MUL_DUTY: begin
				ma = 32'($signed({10'b0, u_q}) - BAND);
				mb = mrac_tlc_pkg::DUTY_FULL;
			end
			default: do_mul = 1'b0;
		endcase
	end

	// tick division: magnitude plus sign, quotient truncates toward zero
	always_comb begin
		case (cmd.op)
			mrac_tlc_pkg::OP_DIV_ACC: dsrc = mrac_tlc_pkg::sat32(66'(acc_q));
			mrac_tlc_pkg::OP_DIV_MV:  dsrc = mv_q;
			default:                  dsrc = t_q;
		endcase
		dsrc33 = 33'(dsrc);
		dneg   = dsrc33[32];
		mag    = dsrc33[32] ? 32'(-dsrc33) : 32'(dsrc33);
	end

	assign recip_p = 64'(mag) * 64'(mrac_tlc_pkg::RECIP_TICK);
	assign tq      = recip_p[mrac_tlc_pkg::RECIP_SHIFT +: TQ_W];

	// duty ratio on the serial divider
	assign dvd       = p_q[DW-1:0];
	assign dvs       = SW'(34'(dmax_q) - BAND);
	assign div_start = cmd.exec && mrac_tlc_pkg::is_div(cmd.op);

	mrac_tlc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (stat.div_done),
		.quotient (quo)
	);

	// drive clamp
	always_comb begin
		s_drive = 36'(acc_q) + 36'(BASE_DRIVE);
		if (s_drive < 0) begin
			u_new = '0;
			f_new = mrac_tlc_pkg::CLAMP_LOW;
		end else if (s_drive > $signed({12'b0, dmax_q})) begin
			u_new = dmax_q;
			f_new = mrac_tlc_pkg::CLAMP_HIGH;
		end else begin
			u_new = s_drive[23:0];
			f_new = mrac_tlc_pkg::CLAMP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q    <= '0;
			a0_q     <= mrac_tlc_pkg::RST_ONE;
			a1_q     <= mrac_tlc_pkg::RST_TWO;
			p1_q     <= mrac_tlc_pkg::RST_ONE;
			p2_q     <= mrac_tlc_pkg::RST_ONE;
			gs_q     <= mrac_tlc_pkg::RST_ONE;
			gr_cfg_q <= mrac_tlc_pkg::RST_ONE;
			dmax_q   <= mrac_tlc_pkg::RST_DRIVE_MAX;
			prev_q   <= '0;
			mp_q     <= '0;
			mv_q     <= '0;
			gp_q     <= '0;
			grt_q    <= '0;
			gf_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mrac_tlc_pkg::REG_REF:       ref_q    <= cfg_data;
					mrac_tlc_pkg::REG_A0:        a0_q     <= cfg_data;
					mrac_tlc_pkg::REG_A1:        a1_q     <= cfg_data;
					mrac_tlc_pkg::REG_P1:        p1_q     <= cfg_data;
					mrac_tlc_pkg::REG_P2:        p2_q     <= cfg_data;
					mrac_tlc_pkg::REG_GAIN_ST:   gs_q     <= cfg_data;
					mrac_tlc_pkg::REG_GAIN_REF:  gr_cfg_q <= cfg_data;
					mrac_tlc_pkg::REG_DRIVE_MAX: dmax_q   <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				case (cmd.op)
					mrac_tlc_pkg::OP_MUL_DIF: prev_q <= x1_q;
					mrac_tlc_pkg::OP_EUL_MV:
						mv_q <= mrac_tlc_pkg::sat32(66'(mv_q) + 66'(qs));
					mrac_tlc_pkg::OP_EUL_MP:
						mp_q <= mrac_tlc_pkg::sat32(66'(mp_q) + 66'(qs));
					mrac_tlc_pkg::OP_EUL_GP:
						gp_q <= mrac_tlc_pkg::sat32(66'(gp_q) + 66'(qs));
					mrac_tlc_pkg::OP_EUL_GR:
						grt_q <= mrac_tlc_pkg::sat32(66'(grt_q) + 66'(qs));
					mrac_tlc_pkg::OP_EUL_GF:
						gf_q <= mrac_tlc_pkg::sat32(66'(gf_q) + 66'(qs));
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			w_q <= load_weight;
		if (cmd.exec && do_mul)
			p_q <= ma * mb;
		if (cmd.exec) begin
			case (cmd.op)
				mrac_tlc_pkg::OP_H:       h_q <= (hs <= 0) ? 32'sd1 : hs;
				mrac_tlc_pkg::OP_X1:
					x1_q <= mrac_tlc_pkg::sat32(66'(h_q) - 66'(OPERATING_HEIGHT));
				mrac_tlc_pkg::OP_X2:      x2_q <= mrac_tlc_pkg::sat32(66'(p_q));
				mrac_tlc_pkg::OP_ACC_NEG: acc_q <= -35'(qm);
				mrac_tlc_pkg::OP_ACC_SUB: acc_q <= acc_q - 35'(qm);
				mrac_tlc_pkg::OP_ACC_ADD: acc_q <= acc_q + 35'(qm);
				mrac_tlc_pkg::OP_ACC_LD:  acc_q <= 35'(qm);
				mrac_tlc_pkg::OP_DIV_ACC, mrac_tlc_pkg::OP_DIV_MV, mrac_tlc_pkg::OP_DIV_T: begin
					tq_q      <= tq;
					div_neg_q <= dneg;
				end
				mrac_tlc_pkg::OP_ERR: begin
					e1_q <= mrac_tlc_pkg::sat32(66'(x1_q) - 66'(mp_q));
					e2_q <= mrac_tlc_pkg::sat32(66'(x2_q) - 66'(mv_q));
				end
				mrac_tlc_pkg::OP_EP:      ep_q <= mrac_tlc_pkg::sat32(66'(acc_q));
				mrac_tlc_pkg::OP_T:       t_q <= qm;
				mrac_tlc_pkg::OP_DQ:      t_q <= mrac_tlc_pkg::sat32(-66'(qm));
				mrac_tlc_pkg::OP_CLAMP: begin
					u_q       <= u_new;
					flag_q    <= f_new;
					band_ok_q <= ($signed({10'b0, u_new}) > BAND) &&
						($signed({10'b0, dmax_q}) > BAND);
				end
				mrac_tlc_pkg::OP_EMIT: begin
					if (!band_ok_q)
						pump_duty <= '0;
					else if (quo > DW'(mrac_tlc_pkg::DUTY_FULL))
						pump_duty <= 8'(mrac_tlc_pkg::DUTY_FULL);
					else
						pump_duty <= quo[7:0];
					control_effort <= u_q;
					effort_clamped <= flag_q;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/mrac_tlc_ctrl.sv -----
// Sequencer: steps through the op program, waits on the divider, owns the input and output handshakes.
// Depends on mrac_tlc_pkg.
`default_nettype none
module mrac_tlc_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output mrac_tlc_pkg::dp_cmd_t         cmd,
	input  wire mrac_tlc_pkg::dp_stat_t   stat
);
	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV} state_t;

	state_t                         state_q;
	logic [mrac_tlc_pkg::PC_W-1:0]  pc_q;
	mrac_tlc_pkg::op_t              op;
	logic                           exec;

	assign op = mrac_tlc_pkg::prog_op(pc_q);
	// the final write waits until the output slot is free
	assign exec = (state_q == ST_RUN) &&
		((op != mrac_tlc_pkg::OP_EMIT) || !out_valid || !out_stall);
	assign in_stall = (state_q != ST_IDLE);
	assign cmd.load = in_valid && (state_q == ST_IDLE);
	assign cmd.exec = exec;
	assign cmd.op   = op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (exec && op == mrac_tlc_pkg::OP_EMIT)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pc_q    <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (exec) begin
						if (mrac_tlc_pkg::is_div(op))
							state_q <= ST_DIV;
						else if (op == mrac_tlc_pkg::OP_EMIT)
							state_q <= ST_IDLE;
						else
							pc_q <= pc_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (stat.div_done) begin
						pc_q    <= pc_q + 1'b1;
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- tb/sv/tb_mrac_tank_level_controller_unit.sv -----
// Testbench for the adaptive tank level controller: random and directed weight items,
// register writes between phases, results checked against a behavioral predictor.
// Depends on mrac_tlc_pkg and mrac_tank_level_controller_unit.
`timescale 1ns / 1ps

class tlc_scoreboard;
	// controller registers
	logic signed [31:0] ref_lvl, a0, a1, p1, p2, kst, kref;
	logic [23:0] umax_cfg;
	// controller state
	logic signed [31:0] prev_dev, mpos, mvel, g_pos, g_rate, g_ref;
	logic [33:0] duty_q[$];
	int errors;

	function new();
		errors = 0;
		ref_lvl = 0; a0 = 65536; a1 = 131072; p1 = 65536; p2 = 65536;
		kst = 65536; kref = 65536; umax_cfg = 24'd786432;
		prev_dev = 0; mpos = 0; mvel = 0; g_pos = 0; g_rate = 0; g_ref = 0;
	endfunction

	function automatic logic signed [31:0] clip(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] qm(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return clip(p >>> 16);
	endfunction

	function automatic logic signed [31:0] tick(input logic signed [31:0] acc,
			input logic signed [31:0] d);
		return clip(longint'(acc) + longint'(d) / 1000);
	endfunction

	function void write_reg(input mrac_tlc_pkg::reg_idx_t idx, input logic [31:0] v);
		case (idx)
			mrac_tlc_pkg::REG_REF:       ref_lvl = v;
			mrac_tlc_pkg::REG_A0:        a0 = v;
			mrac_tlc_pkg::REG_A1:        a1 = v;
			mrac_tlc_pkg::REG_P1:        p1 = v;
			mrac_tlc_pkg::REG_P2:        p2 = v;
			mrac_tlc_pkg::REG_GAIN_ST:   kst = v;
			mrac_tlc_pkg::REG_GAIN_REF:  kref = v;
			mrac_tlc_pkg::REG_DRIVE_MAX: umax_cfg = v[23:0];
			default: ;
		endcase
	endfunction

	function void note_weight(input logic signed [23:0] w);
		longint hw, u, umax, band, duty;
		logic signed [31:0] h, x1, x2, e1, e2, ep, d1, d2, dr;
		logic [1:0] flag;
		hw = longint'(w) * 972182;
		h = clip(hw >>> 24);
		if (h <= 0) h = 1;
		x1 = clip(longint'(h) - 6554);
		x2 = clip((longint'(x1) - longint'(prev_dev)) * 1000);
		prev_dev = x1;
		u = -longint'(qm(a1, mvel)) - longint'(qm(a0, mpos)) + longint'(qm(a0, ref_lvl));
		mvel = tick(mvel, clip(u));
		mpos = tick(mpos, mvel);
		e1 = clip(longint'(x1) - longint'(mpos));
		e2 = clip(longint'(x2) - longint'(mvel));
		ep = clip(longint'(qm(e1, p1)) + longint'(qm(e2, p2)));
		d1 = clip(-longint'(qm(qm(kst, x1), ep)));
		d2 = clip(-longint'(qm(qm(kst, x2), ep)));
		dr = clip(-longint'(qm(qm(kref, ref_lvl), ep)));
		g_pos = tick(g_pos, d1);
		g_rate = tick(g_rate, d2);
		g_ref = tick(g_ref, dr);
		u = longint'(qm(g_pos, x1)) + longint'(qm(g_rate, x2)) + longint'(qm(g_ref, ref_lvl));
		umax = longint'(umax_cfg);
		flag = mrac_tlc_pkg::CLAMP_NONE;
		if (u < 0) begin
			u = 0;
			flag = mrac_tlc_pkg::CLAMP_LOW;
		end else if (u > umax) begin
			u = umax;
			flag = mrac_tlc_pkg::CLAMP_HIGH;
		end
		band = 5 * 65536;
		duty = 0;
		if (u > band && umax > band) begin
			duty = ((u - band) * 255) / (umax - band);
			if (duty > 255) duty = 255;
		end
		duty_q.push_back({duty[7:0], u[23:0], flag});
	endfunction

	function void check_result(input logic [7:0] duty, input logic [23:0] eff,
			input logic [1:0] flag);
		logic [33:0] exp_r;
		if (duty_q.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result duty=%0d u=%0d", duty, eff);
			return;
		end
		exp_r = duty_q.pop_front();
		if (exp_r != {duty, eff, flag}) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: duty %0d/%0d effort %0d/%0d clamp %0d/%0d",
					exp_r[33:26], duty, exp_r[25:2], eff, exp_r[1:0], flag);
		end
	endfunction
endclass

module tb_mrac_tank_level_controller_unit;
	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [23:0] load_weight;
	logic [7:0] pump_duty;
	logic [23:0] control_effort;
	logic [1:0] effort_clamped;
	logic cfg_valid, cfg_ready;
	logic [mrac_tlc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	tlc_scoreboard level_sb;
	int cycles;
	bit quiet_tail;

	mrac_tank_level_controller_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .load_weight(load_weight),
		.out_valid(out_valid), .out_stall(out_stall), .pump_duty(pump_duty),
		.control_effort(control_effort), .effort_clamped(effort_clamped),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// generous watchdog on the total run length; reports failure when it is exceeded
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 4000000) begin
			$display("mrac_tank_level_controller_unit test failed");
			$finish;
		end
	end

	// result side: random stall bursts, check on accept
	initial begin : sink
		int n;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				level_sb.check_result(pump_duty, control_effort, effort_clamped);
			if (n > 0) begin
				n--;
				if (n == 0) out_stall <= 0;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 11);
				out_stall <= 1;
			end
		end
	end

	// valid stays high into the next item unless a random gap is drawn; drain drops it
	task automatic send_weight(input logic signed [23:0] w);
		cfg_valid <= 0;
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1;
		load_weight <= w;
		do @(posedge clk); while (in_stall);
		level_sb.note_weight(w);
	endtask

	task automatic write_reg(input mrac_tlc_pkg::reg_idx_t idx, input logic [31:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		level_sb.write_reg(idx, v);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (level_sb.duty_q.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_weight();
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 200000));
			2: return 24'sd24000 + $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
			default: return -$signed(24'($urandom_range(0, 1000)));
		endcase
	endfunction

	task automatic set_regs(input int mode);
		logic [31:0] v;
		for (int r = 0; r < 7; r++) begin
			case (mode)
				0: v = 32'h7FFFFFFF;
				1: v = 32'h80000000;
				2: v = $urandom;
				default: v = $signed(32'($urandom_range(0, 262144))) - 32'sd131072;
			endcase
			write_reg(mrac_tlc_pkg::reg_idx_t'(r), v);
		end
		case (mode)
			0: v = 32'd16711680;
			1: v = 32'd393216;
			default: v = $urandom_range(393216, 16711680);
		endcase
		write_reg(mrac_tlc_pkg::REG_DRIVE_MAX, v);
	endtask

	initial begin
		level_sb = new();
		cycles = 0;
		quiet_tail = 0;
		in_valid = 0;
		load_weight = 0;
		cfg_valid = 0;
		cfg_index = mrac_tlc_pkg::REG_REF;
		cfg_data = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, tiny height, a repeated mid-range weight, defaults
		send_weight(24'sh7FFFFF);
		send_weight(24'sh800000);
		send_weight(0);
		send_weight(-24'sd1);
		send_weight(24'sd23000);
		send_weight(24'sd23000);
		send_weight(24'sh555555);
		send_weight(24'shAAAAAA);
		for (int i = 0; i < 6; i++) send_weight(24'(60000 * i));
		drain();
		write_reg(mrac_tlc_pkg::REG_REF, 32'sd65536);
		write_reg(mrac_tlc_pkg::REG_DRIVE_MAX, 32'd16711680);
		for (int i = 0; i < 8; i++) send_weight(rand_weight());
		drain();
		set_regs(0);
		for (int i = 0; i < 4; i++) send_weight(rand_weight());
		drain();
		set_regs(1);
		for (int i = 0; i < 4; i++) send_weight(rand_weight());
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			set_regs(ph < 4 ? 3 : 2);
			if (ph == 7) quiet_tail = 1;
			for (int i = 0; i < 250; i++) send_weight(rand_weight());
			drain();
		end

		if (level_sb.errors == 0 && level_sb.duty_q.size() == 0)
			$display("mrac_tank_level_controller_unit test passed");
		else
			$display("mrac_tank_level_controller_unit test failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/mrac_tlc_pkg.sv
rtl/mrac_tlc_div.sv
rtl/mrac_tlc_dp.sv
rtl/mrac_tlc_ctrl.sv
rtl/mrac_tank_level_controller_unit.sv
tb/sv/tb_mrac_tank_level_controller_unit.sv
